/* rtl/hfg_pkg.sv */
`default_nettype none

package hfg_pkg;

   // default values for the top level parameters
   localparam int DEF_HARMONICS  = 4;
   localparam int DEF_ANGLE_BITS = 12;
   localparam int DEF_COEF_BITS  = 16;

   // harmonics that own coefficient registers
   localparam int REG_HARMONICS = 4;

   // field widths
   localparam int LIGHT_BITS      = 15;
   localparam int CHROMA_BITS     = 16;
   localparam int HUE_BITS        = 12;
   localparam int GRAY_BITS       = 24;
   localparam int COEF_FIELD_BITS = 16;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_COS_ONE_TWO     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COS_THREE_FOUR  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIN_ONE_TWO     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIN_THREE_FOUR  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFFSET          = 3'd4;

   // rotator: 16 iterations, init stage and rounding stage
   localparam int CORDIC_STEPS  = 16;
   localparam int CORDIC_STAGES = CORDIC_STEPS + 2;

   // sin/cos values, signed Q1.14 in [-1.0, +1.0]
   localparam int TRIG_BITS      = 16;
   localparam int TRIG_FRAC_BITS = 14;

   typedef logic signed [TRIG_BITS-1:0] trig_type;

endpackage

`default_nettype wire

/* rtl/hfg_cordic.sv */
`default_nettype none

module hfg_cordic #(
   parameter int ANGLE_BITS = hfg_pkg::DEF_ANGLE_BITS
) (
   input  wire                          clock,
   input  wire                          adv,
   input  wire        [ANGLE_BITS-1:0]  angle,
   output hfg_pkg::trig_type            cos_out,
   output hfg_pkg::trig_type            sin_out
);

   localparam int STEPS    = hfg_pkg::CORDIC_STEPS;
   localparam int XY_BITS  = 33;
   localparam int GAIN_Q30 = 652032874;
   localparam int TRIG_ONE = 1 << hfg_pkg::TRIG_FRAC_BITS;
   localparam int RND_BITS = 16;

   // arctan(2^-i) with a full turn of 2^32
   localparam int ROT_ANGLE [STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861
   };

   logic signed [XY_BITS-1:0] x_ff [STEPS+1];
   logic signed [XY_BITS-1:0] y_ff [STEPS+1];
   logic signed [XY_BITS-1:0] z_ff [STEPS+1];
   logic                      flip_ff [STEPS+1];

   logic signed [XY_BITS-1:0] x_in [STEPS];
   logic signed [XY_BITS-1:0] y_in [STEPS];
   logic signed [XY_BITS-1:0] z_in [STEPS];

   logic        [31:0]        angle_full;
   logic                      flip_init;
   logic        [31:0]        angle_fold;

   hfg_pkg::trig_type         cos_ff;
   hfg_pkg::trig_type         sin_ff;

   // round to Q1.14 half up and clamp to one
   function automatic hfg_pkg::trig_type round_trig(input logic signed [XY_BITS-1:0] v);
      logic signed [XY_BITS-1:0] r;
      logic signed [XY_BITS-1:0] c;
      r = (v + XY_BITS'(1 << (RND_BITS - 1))) >>> RND_BITS;
      if (r > XY_BITS'(TRIG_ONE)) begin
         c = XY_BITS'(TRIG_ONE);
      end else if (r < XY_BITS'(-TRIG_ONE)) begin
         c = XY_BITS'(-TRIG_ONE);
      end else begin
         c = r;
      end
      return hfg_pkg::TRIG_BITS'(c);
   endfunction

   // fold the left half plane onto the right one
   always_comb begin
      angle_full = {angle, (32 - ANGLE_BITS)'(0)};
      flip_init  = angle_full[31] ^ angle_full[30];
      angle_fold = angle_full ^ {flip_init, 31'd0};
   end

   // one micro-rotation per stage
   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         if (!z_ff[i][XY_BITS-1]) begin
            x_in[i] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i] = z_ff[i] - XY_BITS'(ROT_ANGLE[i]);
         end else begin
            x_in[i] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i] = z_ff[i] + XY_BITS'(ROT_ANGLE[i]);
         end
      end
   end

   // rotator pipeline, frozen with the rest of the datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= XY_BITS'(GAIN_Q30);
         y_ff[0]    <= '0;
         z_ff[0]    <= XY_BITS'($signed(angle_fold));
         flip_ff[0] <= flip_init;
         for (int i = 0; i < STEPS; i++) begin
            x_ff[i+1]    <= x_in[i];
            y_ff[i+1]    <= y_in[i];
            z_ff[i+1]    <= z_in[i];
            flip_ff[i+1] <= flip_ff[i];
         end
         cos_ff <= flip_ff[STEPS] ? -round_trig(x_ff[STEPS]) : round_trig(x_ff[STEPS]);
         sin_ff <= flip_ff[STEPS] ? -round_trig(y_ff[STEPS]) : round_trig(y_ff[STEPS]);
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

/* rtl/hue_fourier_gray_mapping_top.sv */
`default_nettype none

// channel  ports                                         direction  transaction
// req      req_valid req_stall req_lightness/chroma/hue  in         one LCh pixel
// rsp      rsp_valid rsp_stall rsp_gray_value            out        one gray pixel
// csr      csr_wr_en csr_index csr_wdata                 in         one register write
//
// one pixel per clock while req_stall is low; a transaction accepted at an edge passes through
// the rotator per harmonic and then the multiply/add stages on its way to the rsp ports.
// reset clears the coefficient registers, the stage valid bits and the skid entry.
// a stalled result waits in the output register; one more result lands in the skid
// entry, and only then does the datapath freeze and req_stall rise.

module hue_fourier_gray_mapping_top #(
   parameter int HARMONICS  = hfg_pkg::DEF_HARMONICS,
   parameter int ANGLE_BITS = hfg_pkg::DEF_ANGLE_BITS,
   parameter int COEF_BITS  = hfg_pkg::DEF_COEF_BITS
) (
   input  wire                                        clock,
   input  wire                                        reset,

   input  wire                                        req_valid,
   output logic                                       req_stall,
   input  wire        [hfg_pkg::LIGHT_BITS-1:0]       req_lightness,
   input  wire        [hfg_pkg::CHROMA_BITS-1:0]      req_chroma,
   input  wire        [hfg_pkg::HUE_BITS-1:0]         req_hue_angle,

   output logic                                       rsp_valid,
   input  wire                                        rsp_stall,
   output logic signed [hfg_pkg::GRAY_BITS-1:0]       rsp_gray_value,

   input  wire                                        csr_wr_en,
   input  wire        [hfg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire        [hfg_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int LANES = (HARMONICS < hfg_pkg::REG_HARMONICS) ? HARMONICS
                                                               : hfg_pkg::REG_HARMONICS;
   localparam int CW    = (COEF_BITS < hfg_pkg::COEF_FIELD_BITS) ? COEF_BITS
                                                                 : hfg_pkg::COEF_FIELD_BITS;
   localparam int HALF  = hfg_pkg::COEF_FIELD_BITS;

   // stage indexes after the rotator
   localparam int ST_PROD = hfg_pkg::CORDIC_STAGES;
   localparam int ST_LANE = ST_PROD + 1;
   localparam int ST_SUM  = ST_PROD + 2;
   localparam int ST_MUL  = ST_PROD + 3;
   localparam int ST_ADD  = ST_PROD + 4;

   // datapath widths
   localparam int PROD_BITS  = 31;
   localparam int LANE_BITS  = 32;
   localparam int F_BITS     = 34;
   localparam int FC_BITS    = 51;
   localparam int ACC_BITS   = 52;
   localparam int FRAC_SHIFT = 26;
   localparam int SH_BITS    = ACC_BITS - FRAC_SHIFT;
   localparam int GRAY_MAX   = (1 << (hfg_pkg::GRAY_BITS - 1)) - 1;
   localparam int GRAY_MIN   = -(1 << (hfg_pkg::GRAY_BITS - 1));

   // coefficient registers
   logic        [hfg_pkg::CSR_DATA_BITS-1:0]   cos_reg_ff [2];
   logic        [hfg_pkg::CSR_DATA_BITS-1:0]   sin_reg_ff [2];
   logic        [hfg_pkg::COEF_FIELD_BITS-1:0] offset_ff;

   // flow control
   logic                                       adv;
   logic        [ST_ADD:0]                     valid_ff;
   logic                                       rsp_valid_ff;
   logic                                       rsp_valid_in;
   logic                                       skid_valid_ff;
   logic                                       skid_valid_in;
   logic                                       out_take;
   logic                                       new_item;
   logic                                       out_from_skid;
   logic                                       out_from_pipe;
   logic                                       skid_load;

   // side fields that travel beside the rotators
   logic        [hfg_pkg::LIGHT_BITS-1:0]      l_pipe_ff [ST_ADD];
   logic        [hfg_pkg::CHROMA_BITS-1:0]     c_pipe_ff [ST_MUL];

   // per-harmonic signals
   logic        [ANGLE_BITS-1:0]               hue_w;
   logic        [ANGLE_BITS-1:0]               lane_angle [LANES];
   hfg_pkg::trig_type                          lane_cos   [LANES];
   hfg_pkg::trig_type                          lane_sin   [LANES];
   logic signed [HALF-1:0]                     cos_coef   [LANES];
   logic signed [HALF-1:0]                     sin_coef   [LANES];
   logic signed [HALF-1:0]                     offset_coef;

   // arithmetic stages
   logic signed [PROD_BITS-1:0]                prod_cos_ff [LANES];
   logic signed [PROD_BITS-1:0]                prod_sin_ff [LANES];
   logic signed [PROD_BITS-1:0]                off_term_ff [2];
   logic signed [LANE_BITS-1:0]                lane_sum_ff [LANES];
   logic signed [F_BITS-1:0]                   f_ff;
   logic signed [F_BITS-1:0]                   f_in;
   logic signed [FC_BITS-1:0]                  fc_ff;
   logic signed [ACC_BITS-1:0]                 acc_in;
   logic signed [SH_BITS-1:0]                  acc_sh_ff;
   logic signed [hfg_pkg::GRAY_BITS-1:0]       gray_sat;
   logic signed [hfg_pkg::GRAY_BITS-1:0]       gray_ff;
   logic signed [hfg_pkg::GRAY_BITS-1:0]       gray_in;
   logic signed [hfg_pkg::GRAY_BITS-1:0]       skid_gray_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_reg_ff[0] <= '0;
         cos_reg_ff[1] <= '0;
         sin_reg_ff[0] <= '0;
         sin_reg_ff[1] <= '0;
         offset_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hfg_pkg::REG_COS_ONE_TWO:    cos_reg_ff[0] <= csr_wdata;
            hfg_pkg::REG_COS_THREE_FOUR: cos_reg_ff[1] <= csr_wdata;
            hfg_pkg::REG_SIN_ONE_TWO:    sin_reg_ff[0] <= csr_wdata;
            hfg_pkg::REG_SIN_THREE_FOUR: sin_reg_ff[1] <= csr_wdata;
            hfg_pkg::REG_OFFSET:         offset_ff     <= csr_wdata[HALF-1:0];
            default: begin
            end
         endcase
      end
   end

   // the datapath moves unless the skid entry holds a result
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ST_ADD-1:0], req_valid};
      end
   end

   // lightness and chroma delay lines
   always_ff @(posedge clock) begin
      if (adv) begin
         l_pipe_ff[0] <= req_lightness;
         c_pipe_ff[0] <= req_chroma;
         for (int i = 1; i < ST_ADD; i++) begin
            l_pipe_ff[i] <= l_pipe_ff[i-1];
         end
         for (int i = 1; i < ST_MUL; i++) begin
            c_pipe_ff[i] <= c_pipe_ff[i-1];
         end
      end
   end

   // harmonic angles and coefficient fields
   assign hue_w       = ANGLE_BITS'(req_hue_angle);
   assign offset_coef = HALF'($signed(offset_ff[CW-1:0]));

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      assign lane_angle[j] = ANGLE_BITS'(hue_w * (j + 1));
      assign cos_coef[j]   = HALF'($signed(cos_reg_ff[j/2][HALF*(j%2) +: CW]));
      assign sin_coef[j]   = HALF'($signed(sin_reg_ff[j/2][HALF*(j%2) +: CW]));

      hfg_cordic #(
         .ANGLE_BITS (ANGLE_BITS)
      ) u_cordic (
         .clock   (clock),
         .adv     (adv),
         .angle   (lane_angle[j]),
         .cos_out (lane_cos[j]),
         .sin_out (lane_sin[j])
      );
   end

   // series sum: products, per-harmonic sums, total
   always_comb begin
      f_in = F_BITS'(off_term_ff[1]);
      for (int j = 0; j < LANES; j++) begin
         f_in = f_in + F_BITS'(lane_sum_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < LANES; j++) begin
            prod_cos_ff[j] <= PROD_BITS'(cos_coef[j]) * PROD_BITS'(lane_cos[j]);
            prod_sin_ff[j] <= PROD_BITS'(sin_coef[j]) * PROD_BITS'(lane_sin[j]);
            lane_sum_ff[j] <= LANE_BITS'(prod_cos_ff[j]) + LANE_BITS'(prod_sin_ff[j]);
         end
         off_term_ff[0] <= PROD_BITS'(offset_coef) <<< hfg_pkg::TRIG_FRAC_BITS;
         off_term_ff[1] <= off_term_ff[0];
         f_ff           <= f_in;
      end
   end

   // scale by chroma, add lightness, round half up
   assign acc_in = ACC_BITS'(fc_ff)
                 + (ACC_BITS'(l_pipe_ff[ST_ADD-1]) << FRAC_SHIFT)
                 + ACC_BITS'(1 << (FRAC_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (adv) begin
         fc_ff     <= FC_BITS'(f_ff) * FC_BITS'($signed({1'b0, c_pipe_ff[ST_MUL-1]}));
         acc_sh_ff <= acc_in[ACC_BITS-1:FRAC_SHIFT];
      end
   end

   // saturate to Q15.8
   always_comb begin
      if (acc_sh_ff > SH_BITS'(GRAY_MAX)) begin
         gray_sat = hfg_pkg::GRAY_BITS'(GRAY_MAX);
      end else if (acc_sh_ff < SH_BITS'(GRAY_MIN)) begin
         gray_sat = hfg_pkg::GRAY_BITS'(GRAY_MIN);
      end else begin
         gray_sat = hfg_pkg::GRAY_BITS'(acc_sh_ff);
      end
   end

   // output register with one skid entry
   always_comb begin
      out_take      = rsp_valid_ff && !rsp_stall;
      new_item      = adv && valid_ff[ST_ADD];
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_from_skid = 1'b0;
      out_from_pipe = 1'b0;
      skid_load     = 1'b0;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_from_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (new_item) begin
         if (!rsp_valid_ff || out_take) begin
            out_from_pipe = 1'b1;
            rsp_valid_in  = 1'b1;
         end else begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
      gray_in = out_from_skid ? skid_gray_ff : gray_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_from_skid || out_from_pipe) begin
         gray_ff <= gray_in;
      end
      if (skid_load) begin
         skid_gray_ff <= gray_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_value = gray_ff;

   // the skid entry is only ever occupied behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   // the skid entry fills only when the output result was stalled
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid entry filled without a stalled result");

   // a frozen datapath keeps every transaction in place
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("stage valid bits moved while the datapath was frozen");

   // an accepted pixel always enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted transaction did not enter the pipeline");

endmodule

`default_nettype wire

/* sim/hue_fourier_gray_mapping_top_test.sv */
`default_nettype none

module hue_fourier_gray_mapping_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     IDLE_LIMIT       = 2000;
   localparam int     TAIL_CYCLES      = 40;
   localparam int     RANDOM_PHASES    = 6;
   localparam int     PHASE_PIXELS     = 300;
   localparam int     SHOWN_MISMATCHES = 10;
   localparam longint ROT_GAIN         = 652032874;
   localparam longint TRIG_UNIT        = 16384;
   localparam longint GRAY_TOP         = 8388607;
   localparam longint GRAY_BOTTOM      = -8388608;

   // indexes past the offset register have no register behind them
   localparam logic [hfg_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_LOW  = 3'd5;
   localparam logic [hfg_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_HIGH = 3'd7;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic [hfg_pkg::CSR_INDEX_BITS-1:0]  index;
      logic [hfg_pkg::CSR_DATA_BITS-1:0]   data;
      logic [hfg_pkg::LIGHT_BITS-1:0]      light;
      logic [hfg_pkg::CHROMA_BITS-1:0]     chroma;
      logic [hfg_pkg::HUE_BITS-1:0]        hue;
      bit                                  known;
      logic [hfg_pkg::GRAY_BITS-1:0]       gray;
   } stim_row_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic [hfg_pkg::LIGHT_BITS-1:0]         req_lightness = '0;
   logic [hfg_pkg::CHROMA_BITS-1:0]        req_chroma = '0;
   logic [hfg_pkg::HUE_BITS-1:0]           req_hue_angle = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic signed [hfg_pkg::GRAY_BITS-1:0]   rsp_gray_value;
   logic                                   csr_wr_en = 1'b0;
   logic [hfg_pkg::CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [hfg_pkg::CSR_DATA_BITS-1:0]      csr_wdata = '0;

   // shadow coefficient registers and pending gray values
   logic [hfg_pkg::CSR_DATA_BITS-1:0]      coef_reg [0:4];
   logic [hfg_pkg::GRAY_BITS-1:0]          gray_expected [$];
   stim_row_type                           stimulus_rows [$];

   logic                                   quiet = 1'b0;
   logic [hfg_pkg::GRAY_BITS-1:0]          gray_want;
   int                                     idle_cycles = 0;
   int                                     mismatches = 0;
   int                                     pixels_sent = 0;
   int                                     results_seen = 0;
   int                                     writes_done = 0;
   int                                     coef_sets = 0;

   hue_fourier_gray_mapping_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_lightness  (req_lightness),
      .req_chroma     (req_chroma),
      .req_hue_angle  (req_hue_angle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gray_value (rsp_gray_value),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // rotation angle of each rotator iteration, full turn = 2^32
   function automatic longint arc_step(int i);
      case (i)
         0:  return 536870912;
         1:  return 316933406;
         2:  return 167458907;
         3:  return 85004756;
         4:  return 42667331;
         5:  return 21354465;
         6:  return 10679838;
         7:  return 5340245;
         8:  return 2670163;
         9:  return 1335087;
         10: return 667544;
         11: return 333772;
         12: return 166886;
         13: return 83443;
         14: return 41722;
         default: return 20861;
      endcase
   endfunction

   // Q30 rotator output to Q1.14, clamped to +-1.0
   function automatic longint trig_rounded(longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > TRIG_UNIT) r = TRIG_UNIT;
      if (r < -TRIG_UNIT) r = -TRIG_UNIT;
      return r;
   endfunction

   // cos and sin of a binary angle by vector rotation
   function automatic void unit_vector(input logic [31:0] turn,
                                       output longint cos_q, output longint sin_q);
      longint      x, y, z, dx, dy;
      logic [31:0] a;
      bit          flip;
      int          i;
      a = turn;
      flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
      if (flip) a = a ^ 32'h8000_0000;
      x = ROT_GAIN;
      y = 0;
      z = longint'($signed(a));
      for (i = 0; i < hfg_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arc_step(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arc_step(i);
         end
      end
      cos_q = trig_rounded(x);
      sin_q = trig_rounded(y);
      if (flip) begin
         cos_q = -cos_q;
         sin_q = -sin_q;
      end
   endfunction

   function automatic longint coef_value(logic [hfg_pkg::COEF_FIELD_BITS-1:0] half);
      return longint'($signed(half));
   endfunction

   // gray = lightness + fourier(hue) * chroma, rounded half up, saturated
   function automatic logic [hfg_pkg::GRAY_BITS-1:0] gray_of_pixel(
         logic [hfg_pkg::LIGHT_BITS-1:0] l,
         logic [hfg_pkg::CHROMA_BITS-1:0] c,
         logic [hfg_pkg::HUE_BITS-1:0] h);
      longint                        series, acc, co, si, lv, cv;
      logic [31:0]                   cos_word, sin_word;
      logic [hfg_pkg::HUE_BITS-1:0]  idx;
      int                            k;
      series = coef_value(coef_reg[hfg_pkg::REG_OFFSET][15:0]) * TRIG_UNIT;
      for (k = 1; k <= hfg_pkg::DEF_HARMONICS && k <= hfg_pkg::REG_HARMONICS; k++) begin
         cos_word = (k <= 2) ? coef_reg[hfg_pkg::REG_COS_ONE_TWO]
                             : coef_reg[hfg_pkg::REG_COS_THREE_FOUR];
         sin_word = (k <= 2) ? coef_reg[hfg_pkg::REG_SIN_ONE_TWO]
                             : coef_reg[hfg_pkg::REG_SIN_THREE_FOUR];
         if (k % 2 == 0) begin
            cos_word = cos_word >> 16;
            sin_word = sin_word >> 16;
         end
         idx = hfg_pkg::HUE_BITS'(k * h);
         unit_vector({idx, 20'd0}, co, si);
         series = series + coef_value(cos_word[15:0]) * co
                         + coef_value(sin_word[15:0]) * si;
      end
      lv = longint'(l);
      cv = longint'(c);
      acc = (lv <<< 26) + series * cv;
      acc = (acc + 33554432) >>> 26;
      if (acc > GRAY_TOP) acc = GRAY_TOP;
      if (acc < GRAY_BOTTOM) acc = GRAY_BOTTOM;
      return acc[hfg_pkg::GRAY_BITS-1:0];
   endfunction

   // shadow register update; offset keeps only its low half
   function automatic void apply_write(logic [hfg_pkg::CSR_INDEX_BITS-1:0] idx,
                                       logic [hfg_pkg::CSR_DATA_BITS-1:0] data);
      if (idx <= hfg_pkg::REG_SIN_THREE_FOUR)
         coef_reg[idx] = data;
      else if (idx == hfg_pkg::REG_OFFSET)
         coef_reg[idx] = {16'd0, data[15:0]};
   endfunction

   function automatic logic [hfg_pkg::COEF_FIELD_BITS-1:0] rand_coef();
      logic [11:0] frac;
      frac = 12'($urandom);
      case ($urandom_range(0, 4))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return {{4{frac[11]}}, frac};
         default: return hfg_pkg::COEF_FIELD_BITS'($urandom);
      endcase
   endfunction

   task automatic add_pixel(int l, int c, int h, bit known, int gray);
      stim_row_type r;
      r.kind   = ROW_PIXEL;
      r.index  = '0;
      r.data   = '0;
      r.light  = hfg_pkg::LIGHT_BITS'(l);
      r.chroma = hfg_pkg::CHROMA_BITS'(c);
      r.hue    = hfg_pkg::HUE_BITS'(h);
      r.known  = known;
      r.gray   = hfg_pkg::GRAY_BITS'(gray);
      stimulus_rows.push_back(r);
   endtask

   task automatic add_write(logic [hfg_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [hfg_pkg::CSR_DATA_BITS-1:0] data);
      stim_row_type r;
      r.kind   = ROW_WRITE;
      r.index  = idx;
      r.data   = data;
      r.light  = '0;
      r.chroma = '0;
      r.hue    = '0;
      r.known  = 1'b0;
      r.gray   = '0;
      stimulus_rows.push_back(r);
   endtask

   // one pixel transaction, with an occasional gap in front
   task automatic send_pixel(logic [hfg_pkg::LIGHT_BITS-1:0] l,
                             logic [hfg_pkg::CHROMA_BITS-1:0] c,
                             logic [hfg_pkg::HUE_BITS-1:0] h, bit known,
                             logic [hfg_pkg::GRAY_BITS-1:0] gray);
      if (!quiet && $urandom_range(0, 99) < 5) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_lightness <= l;
      req_chroma    <= c;
      req_hue_angle <= h;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gray_expected.push_back(known ? gray : gray_of_pixel(l, c, h));
      pixels_sent++;
   endtask

   // hold off the sender until every pending gray value is back
   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (gray_expected.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [hfg_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [hfg_pkg::CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_write(idx, data);
      writes_done++;
   endtask

   // receiver stalls at random outside the quiet stretch
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 10);
   end

   // gray result check against the oldest pending value
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (gray_expected.size() == 0) begin
            if (mismatches < SHOWN_MISMATCHES)
               $display("gray result %0d with no pixel pending", rsp_gray_value);
            mismatches++;
         end else begin
            gray_want = gray_expected.pop_front();
            if (rsp_gray_value !== gray_want) begin
               if (mismatches < SHOWN_MISMATCHES)
                  $display("gray mismatch: expected %0d got %0d",
                           $signed(gray_want), rsp_gray_value);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit                                writing;
      int                                phase, n, i;
      logic [hfg_pkg::LIGHT_BITS-1:0]    l;
      logic [hfg_pkg::CHROMA_BITS-1:0]   c;
      logic [hfg_pkg::HUE_BITS-1:0]      h;

      writing = 1'b0;
      for (i = 0; i < 5; i++) coef_reg[i] = '0;

      // reset state: all coefficients zero, gray follows lightness
      add_pixel(0, 0, 0, 1, 0);
      add_pixel(25600, 65535, 4095, 1, 25600);
      add_pixel(32767, 65535, 2048, 1, 32767);
      // writes past the offset register change nothing
      add_write(REG_SPARE_LOW, 32'hFFFF_FFFF);
      add_write(REG_SPARE_LOW + 3'd1, 32'h7FFF_7FFF);
      add_write(REG_SPARE_HIGH, 32'h8000_8000);
      add_pixel(12800, 65535, 1024, 1, 12800);
      add_pixel(1, 1, 3072, 1, 1);
      // offset alone at its negative end, upper half of the write dropped
      add_write(hfg_pkg::REG_OFFSET, 32'hABCD_8000);
      add_pixel(0, 65535, 0, 1, -524280);
      add_pixel(25600, 65535, 2730, 1, -498680);
      add_pixel(100, 0, 4095, 1, 100);
      // every coefficient at its positive end, hues on and near the quadrant edges
      add_write(hfg_pkg::REG_COS_ONE_TWO, 32'h7FFF_7FFF);
      add_write(hfg_pkg::REG_COS_THREE_FOUR, 32'h7FFF_7FFF);
      add_write(hfg_pkg::REG_SIN_ONE_TWO, 32'h7FFF_7FFF);
      add_write(hfg_pkg::REG_SIN_THREE_FOUR, 32'h7FFF_7FFF);
      add_write(hfg_pkg::REG_OFFSET, 32'h0000_7FFF);
      add_pixel(25600, 65535, 0, 0, 0);
      add_pixel(0, 65535, 1, 0, 0);
      add_pixel(32767, 65535, 512, 0, 0);
      add_pixel(12800, 65535, 1023, 0, 0);
      add_pixel(0, 65535, 1024, 0, 0);
      add_pixel(0, 65535, 2048, 0, 0);
      add_pixel(25600, 65535, 3072, 0, 0);
      add_pixel(0, 65535, 4095, 0, 0);
      // every coefficient at its negative end
      add_write(hfg_pkg::REG_COS_ONE_TWO, 32'h8000_8000);
      add_write(hfg_pkg::REG_COS_THREE_FOUR, 32'h8000_8000);
      add_write(hfg_pkg::REG_SIN_ONE_TWO, 32'h8000_8000);
      add_write(hfg_pkg::REG_SIN_THREE_FOUR, 32'h8000_8000);
      add_write(hfg_pkg::REG_OFFSET, 32'hFFFF_8000);
      add_pixel(0, 65535, 0, 0, 0);
      add_pixel(25600, 65535, 1024, 0, 0);
      add_pixel(0, 65535, 1365, 0, 0);
      add_pixel(0, 65535, 2048, 0, 0);
      add_pixel(32767, 65535, 3071, 0, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (stimulus_rows[i]) begin
         if (stimulus_rows[i].kind == ROW_WRITE) begin
            if (!writing) begin
               drain_pixels();
               coef_sets++;
            end
            writing = 1'b1;
            csr_write(stimulus_rows[i].index, stimulus_rows[i].data);
         end else begin
            if (writing) csr_wr_en <= 1'b0;
            writing = 1'b0;
            send_pixel(stimulus_rows[i].light, stimulus_rows[i].chroma,
                       stimulus_rows[i].hue, stimulus_rows[i].known, stimulus_rows[i].gray);
         end
      end

      // random coefficient sets, each followed by random pixels
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_pixels();
         quiet <= (phase == 2);
         csr_write(hfg_pkg::REG_COS_ONE_TWO, {rand_coef(), rand_coef()});
         csr_write(hfg_pkg::REG_COS_THREE_FOUR, {rand_coef(), rand_coef()});
         csr_write(hfg_pkg::REG_SIN_ONE_TWO, {rand_coef(), rand_coef()});
         csr_write(hfg_pkg::REG_SIN_THREE_FOUR, {rand_coef(), rand_coef()});
         csr_write(hfg_pkg::REG_OFFSET, {16'($urandom), rand_coef()});
         if ($urandom_range(0, 1))
            csr_write(REG_SPARE_LOW + hfg_pkg::CSR_INDEX_BITS'($urandom_range(0, 2)),
                      $urandom);
         csr_wr_en <= 1'b0;
         coef_sets++;
         for (n = 0; n < PHASE_PIXELS; n++) begin
            // sender waits out the pipeline once in the middle of a set
            if (phase == 3 && n == PHASE_PIXELS / 2) drain_pixels();
            if ($urandom_range(0, 4) == 0) l = hfg_pkg::LIGHT_BITS'($urandom);
            else l = hfg_pkg::LIGHT_BITS'($urandom_range(0, 25600));
            case ($urandom_range(0, 3))
               0:       c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               1:       c = hfg_pkg::CHROMA_BITS'($urandom_range(0, 4095));
               default: c = hfg_pkg::CHROMA_BITS'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0)
               h = hfg_pkg::HUE_BITS'($urandom_range(0, 7) * 512 + $urandom_range(0, 2) - 1);
            else
               h = hfg_pkg::HUE_BITS'($urandom);
            send_pixel(l, c, h, 1'b0, '0);
         end
      end

      drain_pixels();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("pixels %0d, gray results %0d, register writes %0d over %0d coefficient sets",
               pixels_sent, results_seen, writes_done, coef_sets);
      $display("coefficient extremes, ignored indexes, random stalls and gaps; mismatches %0d",
               mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
